/* hdl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising aclk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

/* hdl/mvps_pkg.sv */
// Package with types and constants of the motor velocity PID with slew limiter.
`timescale 1ns / 1ps

package mvps_pkg;

    // Controller sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_ERR,
        ST_PREP,
        ST_MUL,
        ST_SCALE,
        ST_SLEW,
        ST_DELTA,
        ST_RES
    } state_t;

    // Configuration register indexes
    localparam logic [3:0] REG_PROP_GAIN   = 4'd0;
    localparam logic [3:0] REG_INTEG_GAIN  = 4'd1;
    localparam logic [3:0] REG_DERIV_GAIN  = 4'd2;
    localparam logic [3:0] REG_INTEG_LIMIT = 4'd3;
    localparam logic [3:0] REG_SLEW_LIMIT  = 4'd4;
    localparam logic [3:0] REG_SLEW_ON     = 4'd5;
    localparam logic [3:0] REG_PID_ON      = 4'd6;
    localparam logic [3:0] REG_GEAR_SELECT = 4'd7;

    // Gear select codes
    localparam logic [1:0] GEAR_LOW  = 2'd0;
    localparam logic [1:0] GEAR_HIGH = 2'd2;

    // Voltage limits and setpoint divisor
    localparam logic signed [14:0] VMAX     = 15'sd12000;
    localparam logic signed [14:0] VMIN     = -15'sd12000;
    localparam logic [7:0]         SP_DIV   = 8'd100;
    localparam logic [14:0]        SLEW_RST = 15'd30;

    // Serial step counts (the divide takes its last quotient bit in ST_ERR)
    localparam int DIV_STEPS  = 17;
    localparam int MUL_STEPS  = 16;
    localparam int SLEW_STEPS = 10;

endpackage

/* hdl/motor_velocity_pid_with_slew.sv */
// Top level: velocity PID with slew limiter and output saturation.
//
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  target_mv, measured_rpm, elapsed_ms
// m_        out  m_tvalid/m_tready  drive_mv, slew_limited, clipped
// cfg_      in   cfg_valid/cfg_ready register index, write data
//
// A tick with the PID running goes from accept to result through an 18-step
// serial divide for the setpoint, a 16-step bit-serial multiply over the gains
// and a 10-step serial multiply for the slew step. With the PID off or a changed
// target a tick goes straight to the slew step. One tick is in flight at a time;
// the next one is accepted as soon as the result sits in the output register. A
// stalled output holds the sequencer in its last state. Reset is synchronous.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module motor_velocity_pid_with_slew (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [14:0] target_mv, [25:15] measured_rpm, [35:26] elapsed_ms, [39:36] zero
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [14:0] drive_mv, [15] slew_limited, [16] clipped, [23:17] zero
    output logic [23:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    // Configuration registers
    logic [15:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [19:0] integ_limit_reg;
    logic [14:0] slew_limit_reg;
    logic        slew_on_reg, pid_on_reg;
    logic [1:0]  gear_select_reg;

    // Controller state
    mvps_pkg::state_t state_reg, state_next;
    logic [4:0]         cnt_reg;
    logic signed [14:0] last_target_reg, last_output_reg;
    logic signed [12:0] last_error_reg;
    logic signed [21:0] integ_sum_reg;

    // Datapath
    logic signed [14:0] t_reg;
    logic signed [10:0] meas_reg;
    logic [9:0]         dt_reg, dt_sh_reg;
    logic [17:0]        num_reg;
    logic [6:0]         rem_reg;
    logic signed [12:0] err_reg;
    logic signed [13:0] der_reg;
    logic [15:0]        pg_sh_reg, ig_sh_reg, dg_sh_reg;
    logic signed [39:0] acc_reg;
    logic signed [31:0] calc_reg;
    logic [24:0]        prod_reg;
    logic signed [32:0] delta_reg;

    // Output register
    logic               m_tvalid_reg;
    logic signed [14:0] drive_reg;
    logic               slewed_reg, clip_reg;

    logic out_free, load_out, accept;

    // Input decode and saturation
    logic signed [14:0] in_target, t_sat;
    logic [14:0]        u_val;
    logic [15:0]        u_sum;
    logic [17:0]        v_val;
    logic               run_pid;

    assign in_target = $signed(s_tdata[14:0]);
    always_comb begin
        if (in_target > mvps_pkg::VMAX) begin
            t_sat = mvps_pkg::VMAX;
        end else if (in_target < mvps_pkg::VMIN) begin
            t_sat = mvps_pkg::VMIN;
        end else begin
            t_sat = in_target;
        end
    end
    assign run_pid = pid_on_reg && (t_sat == last_target_reg);

    // Setpoint numerator: (t + 12000) * FS / 120, divided by 100 later
    assign u_sum = 16'($signed({t_reg[14], t_reg}) + 16'sd12000);
    assign u_val = u_sum[14:0];
    always_comb begin
        case (gear_select_reg)
            mvps_pkg::GEAR_LOW:  v_val = {3'b000, u_val};
            mvps_pkg::GEAR_HIGH: v_val = {1'b0, u_val, 2'b00} + {2'b00, u_val, 1'b0};
            default:             v_val = {2'b00, u_val, 1'b0};
        endcase
    end

    // Restoring divide step by the setpoint divisor
    logic [7:0] rem_sh;
    logic       rem_ge;
    logic [7:0] rem_sub;
    assign rem_sh  = {rem_reg, num_reg[17]};
    assign rem_ge  = rem_sh >= mvps_pkg::SP_DIV;
    assign rem_sub = rem_sh - mvps_pkg::SP_DIV;

    // Error against the setpoint
    logic signed [12:0] fs_val, err_val;
    always_comb begin
        case (gear_select_reg)
            mvps_pkg::GEAR_LOW:  fs_val = 13'sd120;
            mvps_pkg::GEAR_HIGH: fs_val = 13'sd720;
            default:             fs_val = 13'sd240;
        endcase
    end
    assign err_val = $signed({2'b00, num_reg[10:0]}) - fs_val
                   - {{2{meas_reg[10]}}, meas_reg};

    // Integral update
    logic [21:0]        isum_mag;
    logic signed [21:0] isum_next;
    assign isum_mag  = integ_sum_reg[21] ? 22'(-integ_sum_reg) : integ_sum_reg;
    assign isum_next = (isum_mag > {2'b00, integ_limit_reg}) ? 22'sd0
                     : integ_sum_reg + {{9{err_val[12]}}, err_val};

    // Bit-serial multiply-accumulate, gain MSB first
    logic signed [39:0] term_p, term_i, term_d, acc_step;
    assign term_p = pg_sh_reg[15] ? 40'(err_reg) : 40'sd0;
    assign term_i = ig_sh_reg[15] ? 40'(integ_sum_reg) : 40'sd0;
    assign term_d = dg_sh_reg[15] ? 40'(der_reg) : 40'sd0;
    assign acc_step = (acc_reg <<< 1) + term_p + term_i + term_d;

    // Q8.8 scale, truncating toward zero
    logic signed [39:0] acc_rnd;
    assign acc_rnd = acc_reg + (acc_reg[39] ? 40'sd255 : 40'sd0);

    // Slew check: |delta| / dt > L  <=>  |delta| >= L*dt + dt
    logic [32:0]        delta_mag, thr;
    logic               slew_hit;
    logic signed [33:0] prev_ext, res_val;
    logic               clip_val;
    logic signed [14:0] res_sat;
    assign delta_mag = delta_reg[32] ? 33'(-delta_reg) : delta_reg;
    assign thr       = {8'b0, prod_reg} + {23'b0, dt_reg};
    assign slew_hit  = slew_on_reg && (delta_reg != 33'sd0) && (delta_mag >= thr);
    assign prev_ext  = 34'(last_output_reg);
    always_comb begin
        if (!slew_hit) begin
            res_val = 34'(calc_reg);
        end else if (delta_reg[32]) begin
            res_val = prev_ext - $signed({9'b0, prod_reg});
        end else begin
            res_val = prev_ext + $signed({9'b0, prod_reg});
        end
    end
    always_comb begin
        if (res_val > 34'(mvps_pkg::VMAX)) begin
            res_sat  = mvps_pkg::VMAX;
            clip_val = 1'b1;
        end else if (res_val < 34'(mvps_pkg::VMIN)) begin
            res_sat  = mvps_pkg::VMIN;
            clip_val = 1'b1;
        end else begin
            res_sat  = res_val[14:0];
            clip_val = 1'b0;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mvps_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = run_pid ? mvps_pkg::ST_DIV : mvps_pkg::ST_SLEW;
                end
            end
            mvps_pkg::ST_DIV: begin
                if (cnt_reg == 5'(mvps_pkg::DIV_STEPS - 1)) state_next = mvps_pkg::ST_ERR;
            end
            mvps_pkg::ST_ERR:  state_next = mvps_pkg::ST_PREP;
            mvps_pkg::ST_PREP: state_next = mvps_pkg::ST_MUL;
            mvps_pkg::ST_MUL: begin
                if (cnt_reg == 5'(mvps_pkg::MUL_STEPS - 1)) state_next = mvps_pkg::ST_SCALE;
            end
            mvps_pkg::ST_SCALE: state_next = mvps_pkg::ST_SLEW;
            mvps_pkg::ST_SLEW: begin
                if (cnt_reg == 5'(mvps_pkg::SLEW_STEPS - 1)) state_next = mvps_pkg::ST_DELTA;
            end
            mvps_pkg::ST_DELTA: state_next = mvps_pkg::ST_RES;
            mvps_pkg::ST_RES: begin
                if (out_free) state_next = mvps_pkg::ST_IDLE;
            end
            default: state_next = mvps_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        out_free = !m_tvalid_reg || m_tready;
        s_tready = (state_reg == mvps_pkg::ST_IDLE);
        load_out = (state_reg == mvps_pkg::ST_RES) && out_free;
    end
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Control, configuration and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= mvps_pkg::ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            integ_limit_reg <= '0;
            slew_limit_reg  <= mvps_pkg::SLEW_RST;
            slew_on_reg     <= 1'b1;
            pid_on_reg      <= 1'b1;
            gear_select_reg <= 2'd1;
            last_target_reg <= '0;
            last_output_reg <= '0;
            last_error_reg  <= '0;
            integ_sum_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_tvalid_reg    <= 1'b1;
                last_output_reg <= res_sat;
                last_target_reg <= t_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (accept && (t_sat != last_target_reg)) begin
                integ_sum_reg <= '0;
            end
            if (state_reg == mvps_pkg::ST_PREP) begin
                integ_sum_reg  <= isum_next;
                last_error_reg <= err_val;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    mvps_pkg::REG_PROP_GAIN:   prop_gain_reg   <= cfg_data[15:0];
                    mvps_pkg::REG_INTEG_GAIN:  integ_gain_reg  <= cfg_data[15:0];
                    mvps_pkg::REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_data[15:0];
                    mvps_pkg::REG_INTEG_LIMIT: integ_limit_reg <= cfg_data;
                    mvps_pkg::REG_SLEW_LIMIT:  slew_limit_reg  <= cfg_data[14:0];
                    mvps_pkg::REG_SLEW_ON:     slew_on_reg     <= cfg_data[0];
                    mvps_pkg::REG_PID_ON:      pid_on_reg      <= cfg_data[0];
                    mvps_pkg::REG_GEAR_SELECT: gear_select_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    // Serial datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            mvps_pkg::ST_IDLE: begin
                t_reg     <= t_sat;
                meas_reg  <= $signed(s_tdata[25:15]);
                dt_reg    <= s_tdata[35:26];
                dt_sh_reg <= s_tdata[35:26];
                calc_reg  <= 32'(t_sat);
                prod_reg  <= '0;
                rem_reg   <= '0;
                cnt_reg   <= '0;
            end
            mvps_pkg::ST_DIV: begin
                if (cnt_reg == 5'd0) begin
                    num_reg <= {v_val[16:0], 1'b0};
                    rem_reg <= {6'b0, v_val[17]};
                end else begin
                    num_reg <= {num_reg[16:0], rem_ge};
                    rem_reg <= rem_ge ? rem_sub[6:0] : rem_sh[6:0];
                end
                cnt_reg <= cnt_reg + 5'd1;
            end
            mvps_pkg::ST_ERR: begin
                // final quotient bit
                num_reg <= {num_reg[16:0], rem_ge};
                rem_reg <= rem_ge ? rem_sub[6:0] : rem_sh[6:0];
            end
            mvps_pkg::ST_PREP: begin
                err_reg   <= err_val;
                pg_sh_reg <= prop_gain_reg;
                ig_sh_reg <= integ_gain_reg;
                dg_sh_reg <= deriv_gain_reg;
                acc_reg   <= '0;
                cnt_reg   <= '0;
            end
            mvps_pkg::ST_MUL: begin
                acc_reg   <= acc_step;
                pg_sh_reg <= {pg_sh_reg[14:0], 1'b0};
                ig_sh_reg <= {ig_sh_reg[14:0], 1'b0};
                dg_sh_reg <= {dg_sh_reg[14:0], 1'b0};
                cnt_reg   <= cnt_reg + 5'd1;
            end
            mvps_pkg::ST_SCALE: begin
                calc_reg <= acc_rnd[39:8];
                prod_reg <= '0;
                cnt_reg  <= '0;
            end
            mvps_pkg::ST_SLEW: begin
                prod_reg  <= {prod_reg[23:0], 1'b0}
                           + (dt_sh_reg[9] ? {10'b0, slew_limit_reg} : 25'd0);
                dt_sh_reg <= {dt_sh_reg[8:0], 1'b0};
                cnt_reg   <= cnt_reg + 5'd1;
            end
            mvps_pkg::ST_DELTA: begin
                delta_reg <= 33'(calc_reg) - 33'(last_output_reg);
            end
            default: ;
        endcase
        if (load_out) begin
            drive_reg  <= res_sat;
            slewed_reg <= slew_hit;
            clip_reg   <= clip_val;
        end
    end

    // Derivative captured together with the fresh error
    always_ff @(posedge aclk) begin
        if (state_reg == mvps_pkg::ST_PREP) begin
            der_reg <= 14'(err_val) - 14'(last_error_reg);
        end
    end

    // The integral update in PREP takes the fresh error straight from err_val.

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, clip_reg, slewed_reg, drive_reg};

    `ASSERT_CLK(a_load_from_res, $rose(m_tvalid_reg) |-> $past(state_reg) == mvps_pkg::ST_RES,
                "result loaded outside the result state")
    `ASSERT_CLK(a_accept_leaves_idle, accept |=> state_reg != mvps_pkg::ST_IDLE,
                "accepted tick did not start the sequencer")
    `ASSERT_NEVER(a_last_out_range,
                  (last_output_reg > mvps_pkg::VMAX) || (last_output_reg < mvps_pkg::VMIN),
                  "stored output outside the voltage range")

endmodule
